>>> rtl/rope_pkg.sv
// Shared types, constants and the CORDIC angle table for the rotary embedding block.
`default_nettype none
package rope_pkg;

    localparam int PAIR_COUNT_DEFAULT    = 64;
    localparam int POSITION_BITS_DEFAULT = 24;

    localparam int CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // input action codes
    localparam logic [1:0] ACT_ROTATE = 2'd0;
    localparam logic [1:0] ACT_PASS   = 2'd1;
    localparam logic [1:0] ACT_LOAD   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ROT_EN   = 2'd0;
    localparam logic [1:0] CFG_QSCL_EN  = 2'd1;
    localparam logic [1:0] CFG_QSCL     = 2'd2;

    typedef struct packed {
        logic valid;
        logic rot;
        logic scale;
        logic flip;
    } t_ctl;

    // atan(2^-i) in units of 2^-32 turns
    function automatic logic signed [33:0] atan_turns(input int i);
        logic signed [33:0] a;
        unique case (i)
            0:  a = 34'sd536870912;
            1:  a = 34'sd316933406;
            2:  a = 34'sd167458907;
            3:  a = 34'sd85004756;
            4:  a = 34'sd42667331;
            5:  a = 34'sd21354465;
            6:  a = 34'sd10679838;
            7:  a = 34'sd5340245;
            8:  a = 34'sd2670163;
            9:  a = 34'sd1335087;
            10: a = 34'sd667544;
            11: a = 34'sd333772;
            12: a = 34'sd166886;
            13: a = 34'sd83443;
            14: a = 34'sd41722;
            15: a = 34'sd20861;
            16: a = 34'sd10430;
            17: a = 34'sd5215;
            18: a = 34'sd2608;
            19: a = 34'sd1304;
            20: a = 34'sd652;
            21: a = 34'sd326;
            22: a = 34'sd163;
            23: a = 34'sd81;
            24: a = 34'sd41;
            25: a = 34'sd20;
            26: a = 34'sd10;
            27: a = 34'sd5;
            28: a = 34'sd3;
            29: a = 34'sd1;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

>>> rtl/rope_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rope_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/rotary_position_embedding.sv
// Top level of the rotary position embedding pipeline.
//
// Rotates one Q16.16 pair per clock by 2*pi*frac(position * frequency), with the
// per-pair frequency (Q0.32 turns) held in an on-chip table that software fills
// with load transfers before any rotate reads that entry. The pipeline accepts a
// new transfer every cycle while it is not held; each item passes through the
// table read, the phase multiply, the 30-step CORDIC, one step per stage, and
// the product, rounding, scaling and saturation stages. Load and unused actions
// leave a bubble and give no result. The whole pipeline holds only while the
// output register is full and not taken. Configuration is to be written with no
// item in flight; the user must keep to this, the block does not enforce it.
`default_nettype none
module rotary_position_embedding
    import rope_pkg::*;
#(
    parameter int PAIR_COUNT    = PAIR_COUNT_DEFAULT,
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    localparam int DIN = 6 + POSITION_BITS + 96,
    localparam int DW  = ((DIN + 7) / 8) * 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // slave: tdata = pair_index, position, first_value, second_value, frequency_turns
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [DW-1:0] i_s_tdata,
    // slave: tuser = action[1:0], is_query
    input  wire logic [2:0]    i_s_tuser,
    // master: tdata = first_result, second_result
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [63:0]        o_m_tdata,
    // configuration writes
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [16:0]   i_cfg_data
);
    localparam int AW    = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
    localparam int S_PH  = 1;
    localparam int S_C0  = 2;
    localparam int S_MUL = S_C0 + CORDIC_STEPS + 1;
    localparam int S_SUM = S_MUL + 1;
    localparam int S_SCL = S_SUM + 1;
    localparam int S_OUT = S_SCL + 1;
    localparam int NS    = S_OUT + 1;

    // unpack input fields
    logic [1:0]               in_action;
    logic                     in_query;
    logic [5:0]               in_idx;
    logic [POSITION_BITS-1:0] in_pos;
    logic signed [31:0]       in_x0;
    logic signed [31:0]       in_x1;
    logic [31:0]              in_freq;

    assign in_action = i_s_tuser[1:0];
    assign in_query  = i_s_tuser[2];
    assign in_idx    = i_s_tdata[5:0];
    assign in_pos    = i_s_tdata[6 +: POSITION_BITS];
    assign in_x0     = i_s_tdata[6 + POSITION_BITS +: 32];
    assign in_x1     = i_s_tdata[38 + POSITION_BITS +: 32];
    assign in_freq   = i_s_tdata[70 + POSITION_BITS +: 32];

    // configuration registers
    logic        r_rot_en;
    logic        r_qscl_en;
    logic [16:0] r_qscl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_en  <= 1'b1;
            r_qscl_en <= 1'b0;
            r_qscl    <= 17'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROT_EN:  r_rot_en  <= i_cfg_data[0];
                CFG_QSCL_EN: r_qscl_en <= i_cfg_data[0];
                CFG_QSCL:    r_qscl    <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // pipeline advance: hold everything while the output waits
    logic adv;
    logic accept;
    t_ctl r_ctl [NS];

    assign adv        = !r_ctl[S_OUT].valid || i_m_tready;
    assign o_s_tready = adv;
    assign accept     = i_s_tvalid && adv;

    // table addressing with range check
    logic [AW+5:0] idx_wide;
    logic [AW-1:0] tbl_addr;
    logic          in_range;

    assign idx_wide = {{AW{1'b0}}, in_idx};
    assign tbl_addr = idx_wide[AW-1:0];
    assign in_range = (idx_wide < (AW + 6)'(PAIR_COUNT));

    logic [31:0] tbl_q;

    rope_ram #(
        .WIDTH (32),
        .DEPTH (PAIR_COUNT)
    ) u_freq_ram (
        .i_clk   (i_clk),
        .i_we    (accept && in_action == ACT_LOAD && in_range),
        .i_waddr (tbl_addr),
        .i_wdata (in_freq),
        .i_re    (accept),
        .i_raddr (tbl_addr),
        .o_rdata (tbl_q)
    );

    // entry control
    t_ctl n_ctl0;
    logic [POSITION_BITS+31:0] pos_wide;

    assign pos_wide = {32'b0, in_pos};

    always_comb begin
        n_ctl0.valid = accept && (in_action == ACT_ROTATE || in_action == ACT_PASS);
        n_ctl0.rot   = n_ctl0.valid && in_action == ACT_ROTATE && r_rot_en && in_range;
        n_ctl0.scale = n_ctl0.valid && in_query && r_qscl_en;
        n_ctl0.flip  = 1'b0;
    end

    // phase and fold
    logic [31:0] r_pos32;
    logic [31:0] r_phase;
    logic        fold;
    t_ctl        ph_ctl;

    assign fold = r_phase[31] ^ r_phase[30];

    // mark the fold only on rotating items; bubbles carry no phase
    always_comb begin
        ph_ctl      = r_ctl[S_PH];
        ph_ctl.flip = fold && r_ctl[S_PH].rot;
    end

    // control shift line; flip is set when the phase is folded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (adv) begin
            r_ctl[0] <= n_ctl0;
            for (int k = 1; k < NS; k++) begin
                if (k == S_C0) begin
                    r_ctl[k] <= ph_ctl;
                end else begin
                    r_ctl[k] <= r_ctl[k-1];
                end
            end
        end
    end

    // value shift line up to the sum stage
    logic signed [31:0] r_x0 [S_SUM];
    logic signed [31:0] r_x1 [S_SUM];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x0[0]  <= in_x0;
            r_x1[0]  <= in_x1;
            r_pos32  <= pos_wide[31:0];
            r_phase  <= 32'(r_pos32 * tbl_q);
            for (int k = 1; k < S_SUM; k++) begin
                r_x0[k] <= r_x0[k-1];
                r_x1[k] <= r_x1[k-1];
            end
        end
    end

    // CORDIC, one micro-rotation per stage
    logic signed [33:0] r_cx [CORDIC_STEPS+1];
    logic signed [33:0] r_cy [CORDIC_STEPS+1];
    logic signed [33:0] r_cz [CORDIC_STEPS+1];
    logic [31:0]        z_init;

    assign z_init = fold ? (r_phase ^ 32'h8000_0000) : r_phase;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cx[0] <= CORDIC_GAIN_Q30;
            r_cy[0] <= '0;
            r_cz[0] <= {{2{z_init[31]}}, z_init};
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (!r_cz[i][33]) begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - atan_turns(i);
                end else begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + atan_turns(i);
                end
            end
        end
    end

    // products, sums with fold sign and rounding, scaling, saturation
    logic signed [65:0] r_p00, r_p11, r_p01, r_p10;
    logic signed [66:0] sum0, sum1, rnd0, rnd1;
    logic signed [36:0] r_v0, r_v1;
    logic signed [54:0] r_sp0, r_sp1;
    logic signed [36:0] r_w0, r_w1;
    logic signed [54:0] srnd0, srnd1;
    logic signed [38:0] fin0, fin1;
    logic signed [17:0] qs_s;
    logic [63:0]        r_out;

    assign qs_s = signed'({1'b0, r_qscl});
    assign sum0 = r_ctl[S_SUM-1].flip ? -(67'(r_p00) - 67'(r_p11)) : 67'(r_p00) - 67'(r_p11);
    assign sum1 = r_ctl[S_SUM-1].flip ? -(67'(r_p01) + 67'(r_p10)) : 67'(r_p01) + 67'(r_p10);
    assign rnd0 = sum0 + 67'sd536870912;
    assign rnd1 = sum1 + 67'sd536870912;
    assign srnd0 = r_sp0 + 55'sd32768;
    assign srnd1 = r_sp1 + 55'sd32768;
    assign fin0 = r_ctl[S_OUT-1].scale ? srnd0[54:16] : 39'(r_w0);
    assign fin1 = r_ctl[S_OUT-1].scale ? srnd1[54:16] : 39'(r_w1);

    function automatic logic [31:0] sat32(input logic signed [38:0] v);
        logic [31:0] s;
        if (v > 39'sd2147483647) begin
            s = 32'h7FFF_FFFF;
        end else if (v < -39'sd2147483648) begin
            s = 32'h8000_0000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p00 <= r_x0[S_MUL-1] * r_cx[CORDIC_STEPS];
            r_p11 <= r_x1[S_MUL-1] * r_cy[CORDIC_STEPS];
            r_p01 <= r_x0[S_MUL-1] * r_cy[CORDIC_STEPS];
            r_p10 <= r_x1[S_MUL-1] * r_cx[CORDIC_STEPS];
            if (r_ctl[S_SUM-1].rot) begin
                r_v0 <= rnd0[66:30];
                r_v1 <= rnd1[66:30];
            end else begin
                r_v0 <= 37'(r_x0[S_SUM-1]);
                r_v1 <= 37'(r_x1[S_SUM-1]);
            end
            r_sp0 <= r_v0 * qs_s;
            r_sp1 <= r_v1 * qs_s;
            r_w0  <= r_v0;
            r_w1  <= r_v1;
            r_out <= {sat32(fin1), sat32(fin0)};
        end
    end

    assign o_m_tvalid = r_ctl[S_OUT].valid;
    assign o_m_tdata  = r_out;

    // a load action leaves a bubble
    a_load_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_action == ACT_LOAD) |=> !r_ctl[0].valid)
        else $error("load produced a result slot");

    // rotate flag only on live items
    a_rot_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[S_PH].rot |-> r_ctl[S_PH].valid)
        else $error("rotate flag on a bubble");

    // stalled pipeline keeps the control of the first CORDIC stage
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_ctl[S_C0]))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire
